// ----- design/imsu_pkg.sv -----
// Shared types, constants and exponent tables for the Ising spin update block.
package imsu_pkg;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_COUPLING_J = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIELD_H    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MOMENT_MU  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_TEMP   = 2'd3;

  localparam int DE_W   = 21;
  localparam int SUM_W  = 12;
  localparam int DRAW_W = 10;
  localparam int TAB_W  = 17;
  localparam int TINT_N = 12;
  localparam int ACCEPT_SCALE = 1000;

  typedef logic [TAB_W-1:0] tfrac_tab_t [256];

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_LD_RD, ST_LD_WR, ST_RD_S, ST_RD_U, ST_RD_D, ST_RD_L,
    ST_RD_R, ST_ACC, ST_E1, ST_E2, ST_E3, ST_E4, ST_COMMIT
  } state_t;

  typedef enum logic [2:0] {
    RS_SELF, RS_UP, RS_DOWN, RS_LEFT, RS_RIGHT
  } rd_sel_t;

  typedef struct packed {
    logic    capture;
    logic    clr_wr;
    rd_sel_t rd_sel;
    logic    lat_self;
    logic    nb_init;
    logic    nb_acc;
    logic    e1;
    logic    e2;
    logic    e3;
    logic    e4;
    logic    commit_ld;
    logic    commit_fl;
  } cmd_t;

  typedef struct packed {
    logic func;
    logic clr_last;
  } status_t;

  // round(65536 * e^-k)
  function automatic logic [TAB_W-1:0] tint(input logic [3:0] k);
    case (k)
      4'd0:    tint = 17'd65536;
      4'd1:    tint = 17'd24109;
      4'd2:    tint = 17'd8869;
      4'd3:    tint = 17'd3263;
      4'd4:    tint = 17'd1200;
      4'd5:    tint = 17'd442;
      4'd6:    tint = 17'd162;
      4'd7:    tint = 17'd60;
      4'd8:    tint = 17'd22;
      4'd9:    tint = 17'd8;
      4'd10:   tint = 17'd3;
      4'd11:   tint = 17'd1;
      default: tint = 17'd0;
    endcase
  endfunction

  // round(65536 * e^(-f/256)), evaluated at elaboration
  function automatic tfrac_tab_t build_tfrac();
    tfrac_tab_t t;
    for (int f = 0; f < 256; f++) begin
      t[f] = TAB_W'($rtoi(65536.0 * $exp(-real'(f) / 256.0) + 0.5));
    end
    return t;
  endfunction

endpackage

// ----- design/imsu_if.sv -----
// Valid/ready channel interfaces for input and result words.
interface imsu_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [4:0] row;
  logic [4:0] col;
  logic       spin_up_in;
  logic [9:0] draw;
  modport source (output valid, func, row, col, spin_up_in, draw, input ready);
  modport sink (input valid, func, row, col, spin_up_in, draw, output ready);
endinterface

interface imsu_out_if;
  logic               valid;
  logic               ready;
  logic               spin_up_out;
  logic               flipped;
  logic signed [20:0] delta_energy;
  logic signed [11:0] spin_sum;
  modport source (output valid, spin_up_out, flipped, delta_energy, spin_sum, input ready);
  modport sink (input valid, spin_up_out, flipped, delta_energy, spin_sum, output ready);
endinterface

// ----- design/ising_metropolis_spin_update_top.sv -----
// One word at a time: a load reads its own site and then writes it; a flip reads its own site and
// four wrapped neighbors in turn from one memory port, then takes four arithmetic steps; each
// result is committed once the output register is free.
// Reset: synchronous active-low; afterwards a clearing pass over all ROWS*COLS sites sets
// every spin down while in_ch.ready stays low; config registers take reset values.
// A finished result waits in the output register while the next word is accepted.
module ising_metropolis_spin_update_top
  import imsu_pkg::*;
#(
  parameter int ROWS = 32,
  parameter int COLS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [15:0]          cfg_data,
  imsu_in_if.sink              in_ch,
  imsu_out_if.source           out_ch
);

  cmd_t    cmd;
  status_t sts;

  // sequencer: owns handshakes and step order
  imsu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // lattice memory, running sum and energy arithmetic
  imsu_dp #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_idx          (cfg_idx),
    .cfg_data         (cfg_data),
    .in_func          (in_ch.func),
    .in_row           (in_ch.row),
    .in_col           (in_ch.col),
    .in_spin_up_in    (in_ch.spin_up_in),
    .in_draw          (in_ch.draw),
    .cmd              (cmd),
    .sts              (sts),
    .out_spin_up_out  (out_ch.spin_up_out),
    .out_flipped      (out_ch.flipped),
    .out_delta_energy (out_ch.delta_energy),
    .out_spin_sum     (out_ch.spin_sum)
  );

endmodule

// ----- design/imsu_ctrl.sv -----
// Controller state machine: clearing pass, site reads, energy steps, commit.
module imsu_ctrl
  import imsu_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t sts,
  output cmd_t    cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.rd_sel    = RS_SELF;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_RD_S;
        end
      end
      ST_RD_S: begin
        cmd.rd_sel = RS_SELF;
        state_nxt  = sts.func ? ST_RD_U : ST_LD_RD;
      end
      // read of own site already issued; data lands next cycle
      ST_LD_RD: state_nxt = ST_LD_WR;
      ST_LD_WR: begin
        if (out_free) begin
          cmd.commit_ld = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_RD_U: begin
        cmd.rd_sel   = RS_UP;
        cmd.lat_self = 1'b1;
        state_nxt    = ST_RD_D;
      end
      ST_RD_D: begin
        cmd.rd_sel  = RS_DOWN;
        cmd.nb_init = 1'b1;
        state_nxt   = ST_RD_L;
      end
      ST_RD_L: begin
        cmd.rd_sel = RS_LEFT;
        cmd.nb_acc = 1'b1;
        state_nxt  = ST_RD_R;
      end
      ST_RD_R: begin
        cmd.rd_sel = RS_RIGHT;
        cmd.nb_acc = 1'b1;
        state_nxt  = ST_ACC;
      end
      ST_ACC: begin
        cmd.nb_acc = 1'b1;
        state_nxt  = ST_E1;
      end
      ST_E1: begin
        cmd.e1    = 1'b1;
        state_nxt = ST_E2;
      end
      ST_E2: begin
        cmd.e2    = 1'b1;
        state_nxt = ST_E3;
      end
      ST_E3: begin
        cmd.e3    = 1'b1;
        state_nxt = ST_E4;
      end
      ST_E4: begin
        cmd.e4    = 1'b1;
        state_nxt = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (out_free) begin
          cmd.commit_fl = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ----- design/imsu_dp.sv -----
// Datapath: spin memory, config registers, energy and acceptance arithmetic.
module imsu_dp
  import imsu_pkg::*;
#(
  parameter int ROWS = 32,
  parameter int COLS = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_idx,
  input  logic [15:0]              cfg_data,
  input  logic                     in_func,
  input  logic [4:0]               in_row,
  input  logic [4:0]               in_col,
  input  logic                     in_spin_up_in,
  input  logic [DRAW_W-1:0]        in_draw,
  input  cmd_t                     cmd,
  output status_t                  sts,
  output logic                     out_spin_up_out,
  output logic                     out_flipped,
  output logic signed [DE_W-1:0]   out_delta_energy,
  output logic signed [SUM_W-1:0]  out_spin_sum
);

  localparam int NS = ROWS * COLS;
  localparam int IW = $clog2(NS);
  localparam int RW = $clog2(ROWS);
  localparam int CW = $clog2(COLS);
  localparam int SW = IW + 2;
  localparam tfrac_tab_t TFRAC = build_tfrac();

  logic mem_r [NS];
  logic rdata_r;

  logic signed [15:0] coupling_j_r, field_h_r, moment_mu_r;
  logic [15:0]        inv_temp_r;
  logic signed [31:0] mh_r;

  logic [RW-1:0]     row_r;
  logic [CW-1:0]     col_r;
  logic              func_r, spin_in_r;
  logic [DRAW_W-1:0] draw_r;
  logic [IW-1:0]     clr_addr_r;
  logic signed [SW-1:0] sum_r, sum_nxt;

  logic              self_r;
  logic signed [3:0] nb_r;
  logic signed [DE_W-1:0] de_r;
  logic              neg_r, kbig_r;
  logic [35:0]       prod_r;
  logic [2*TAB_W-1:0] pt_r;
  logic [25:0]       pm_r;

  logic [RW-1:0] rd_row;
  logic [CW-1:0] rd_col;
  logic [IW-1:0] rd_addr, self_addr, wr_addr;
  logic          mem_we, wr_data;
  logic signed [21:0] t_v, de_v;
  logic [23:0]   x_v;
  logic [18:0]   p_rnd;
  logic [15:0]   p_v;
  logic          accept;

  assign sts.func     = func_r;
  assign sts.clr_last = (clr_addr_r == IW'(NS - 1));

  // neighbour address with periodic wrap
  always_comb begin
    rd_row = row_r;
    rd_col = col_r;
    case (cmd.rd_sel)
      RS_UP:    rd_row = (row_r == '0) ? RW'(ROWS - 1) : row_r - 1'b1;
      RS_DOWN:  rd_row = (row_r == RW'(ROWS - 1)) ? '0 : row_r + 1'b1;
      RS_LEFT:  rd_col = (col_r == '0) ? CW'(COLS - 1) : col_r - 1'b1;
      RS_RIGHT: rd_col = (col_r == CW'(COLS - 1)) ? '0 : col_r + 1'b1;
      default:  ;
    endcase
  end

  assign rd_addr   = IW'(IW'(rd_row) * IW'(COLS) + IW'(rd_col));
  assign self_addr = IW'(IW'(row_r) * IW'(COLS) + IW'(col_r));

  // flip decision from the registered table product
  assign accept = neg_r || ({draw_r, 16'b0} < pm_r);

  always_comb begin
    mem_we  = 1'b0;
    wr_addr = self_addr;
    wr_data = 1'b0;
    sum_nxt = sum_r;
    if (cmd.clr_wr) begin
      mem_we  = 1'b1;
      wr_addr = clr_addr_r;
    end else if (cmd.commit_ld) begin
      mem_we  = 1'b1;
      wr_data = spin_in_r;
      if (rdata_r != spin_in_r) sum_nxt = spin_in_r ? sum_r + SW'(2) : sum_r - SW'(2);
    end else if (cmd.commit_fl && accept) begin
      mem_we  = 1'b1;
      wr_data = !self_r;
      sum_nxt = self_r ? sum_r - SW'(2) : sum_r + SW'(2);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem_r[wr_addr] <= wr_data;
    rdata_r <= mem_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coupling_j_r <= 16'sd4096;
      field_h_r    <= 16'sd0;
      moment_mu_r  <= 16'sd4096;
      inv_temp_r   <= 16'd256;
      clr_addr_r   <= '0;
      sum_r        <= -SW'(NS);
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_COUPLING_J: coupling_j_r <= cfg_data;
          CFG_FIELD_H:    field_h_r    <= cfg_data;
          CFG_MOMENT_MU:  moment_mu_r  <= cfg_data;
          CFG_INV_TEMP:   inv_temp_r   <= cfg_data;
          default:        ;
        endcase
      end
      if (cmd.clr_wr) clr_addr_r <= clr_addr_r + 1'b1;
      sum_r <= sum_nxt;
    end
  end

  always_comb begin
    t_v   = 22'(coupling_j_r) * 22'(nb_r) + 22'(mh_r >>> 12);
    de_v  = self_r ? (t_v <<< 1) : -(t_v <<< 1);
    x_v   = prod_r[35:12];
    p_rnd = 19'((pt_r + 34'd32768) >> 16);
    p_v   = kbig_r ? 16'd0 : ((p_rnd > 19'd65535) ? 16'hFFFF : p_rnd[15:0]);
  end

  always_ff @(posedge clk) begin
    mh_r <= moment_mu_r * field_h_r;
    if (cmd.capture) begin
      func_r    <= in_func;
      row_r     <= RW'(in_row % ROWS);
      col_r     <= CW'(in_col % COLS);
      spin_in_r <= in_spin_up_in;
      draw_r    <= in_draw;
    end
    if (cmd.lat_self) self_r <= rdata_r;
    if (cmd.nb_init)  nb_r <= rdata_r ? 4'sd1 : -4'sd1;
    else if (cmd.nb_acc) nb_r <= nb_r + (rdata_r ? 4'sd1 : -4'sd1);
    if (cmd.e1) de_r <= DE_W'(de_v);
    if (cmd.e2) begin
      neg_r  <= de_r[DE_W-1];
      prod_r <= 36'(de_r[19:0]) * 36'(inv_temp_r);
    end
    if (cmd.e3) begin
      kbig_r <= (x_v[23:8] >= 16'(TINT_N));
      pt_r   <= (2*TAB_W)'(tint(x_v[11:8])) * (2*TAB_W)'(TFRAC[x_v[7:0]]);
    end
    if (cmd.e4) pm_r <= 26'(p_v) * 26'(ACCEPT_SCALE);
    if (cmd.commit_ld) begin
      out_spin_up_out  <= spin_in_r;
      out_flipped      <= 1'b0;
      out_delta_energy <= '0;
      out_spin_sum     <= SUM_W'(sum_nxt);
    end else if (cmd.commit_fl) begin
      out_spin_up_out  <= accept ? !self_r : self_r;
      out_flipped      <= accept;
      out_delta_energy <= de_r;
      out_spin_sum     <= SUM_W'(sum_nxt);
    end
  end

endmodule

// ----- dv/ising_metropolis_spin_update_checker.sv -----
// Checker: predicts Ising spin update results and compares against the result channel.
module ising_metropolis_spin_update_checker
  import imsu_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [15:0] cfg_data,
  imsu_in_if          in_ch,
  imsu_out_if         out_ch,
  output int          fail_count,
  output int          words_pending
);

  typedef struct {
    bit          spin;
    bit          flip;
    logic [20:0] de;
    logic [11:0] sum;
  } spin_result_t;

  localparam longint unsigned EXP_INT [12] = '{65536, 24109, 8869, 3263, 1200, 442,
                                               162, 60, 22, 8, 3, 1};

  longint unsigned exp_frac [256];
  bit              lattice [1024];
  int              mag_sum;
  longint          coup_j, fld_h, mom_mu;
  longint unsigned beta;
  spin_result_t    expected_q [$];

  // e^(-f/256) in Q.16 from an integer Taylor series
  initial begin
    longint unsigned term, pos, neg;
    for (int f = 0; f < 256; f++) begin
      term = 64'd1 << 54;
      pos  = term;
      neg  = 0;
      for (int n = 1; n < 40; n++) begin
        term = (term * f) / (256 * n);
        if (n & 1) neg += term;
        else pos += term;
      end
      exp_frac[f] = (pos - neg + (64'd1 << 37)) >> 38;
    end
  end

  function automatic spin_result_t predict_spin_update(input bit func, input int r,
                                                      input int c, input bit up,
                                                      input longint unsigned draw);
    spin_result_t    res;
    int              idx, s, nsum;
    longint          t, de;
    longint unsigned x, k, p;
    bit              accept;
    idx = r * 32 + c;
    res.flip = 0;
    de = 0;
    if (func == 1'b0) begin
      if (lattice[idx] != up) mag_sum += up ? 2 : -2;
      lattice[idx] = up;
    end else begin
      s = lattice[idx] ? 1 : -1;
      nsum = (lattice[((r + 31) % 32) * 32 + c] ? 1 : -1)
           + (lattice[((r + 1) % 32) * 32 + c] ? 1 : -1)
           + (lattice[r * 32 + (c + 31) % 32] ? 1 : -1)
           + (lattice[r * 32 + (c + 1) % 32] ? 1 : -1);
      t = coup_j * nsum + ((mom_mu * fld_h) >>> 12);
      de = 2 * s * t;
      if (de < 0) begin
        accept = 1;
      end else begin
        x = (longint'(de) * beta) >> 12;
        k = x >> 8;
        p = 0;
        if (k < 12) begin
          p = (EXP_INT[k] * exp_frac[x & 255] + 32768) >> 16;
          if (p > 65535) p = 65535;
        end
        accept = draw * 65536 < p * 1000;
      end
      if (accept) begin
        res.flip = 1;
        mag_sum += lattice[idx] ? -2 : 2;
        lattice[idx] = !lattice[idx];
      end
    end
    res.spin = lattice[idx];
    res.de   = de[20:0];
    res.sum  = mag_sum[11:0];
    return res;
  endfunction

  always @(posedge clk) begin
    spin_result_t want;
    if (!rst_n) begin
      foreach (lattice[i]) lattice[i] = 0;
      mag_sum = -1024;
      coup_j  = 4096;
      fld_h   = 0;
      mom_mu  = 4096;
      beta    = 256;
      expected_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_COUPLING_J: coup_j = longint'($signed(cfg_data));
          CFG_FIELD_H:    fld_h  = longint'($signed(cfg_data));
          CFG_MOMENT_MU:  mom_mu = longint'($signed(cfg_data));
          CFG_INV_TEMP:   beta   = cfg_data;
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result word");
        end else begin
          want = expected_q.pop_front();
          if (want.spin !== out_ch.spin_up_out || want.flip !== out_ch.flipped ||
              want.de !== out_ch.delta_energy || want.sum !== out_ch.spin_sum) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: exp spin=%0d flip=%0d de=%0d sum=%0d got %0d %0d %0d %0d",
                       want.spin, want.flip, $signed(want.de), $signed(want.sum),
                       out_ch.spin_up_out, out_ch.flipped, out_ch.delta_energy,
                       out_ch.spin_sum);
          end
        end
      end
      if (in_ch.valid && in_ch.ready)
        expected_q.push_back(predict_spin_update(in_ch.func, in_ch.row, in_ch.col,
                                                 in_ch.spin_up_in, in_ch.draw));
    end
    words_pending = expected_q.size();
  end

endmodule

// ----- dv/ising_metropolis_spin_update_top_test.sv -----
// Testbench top: stimulus, receiver stalls and verdict for the Ising spin update block.
module ising_metropolis_spin_update_top_test;
  import imsu_pkg::*;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        cfg_we = 0;
  logic [1:0]  cfg_idx = '0;
  logic [15:0] cfg_data = '0;
  int          fail_count;
  int          words_pending;
  int          cycles = 0;
  bit          no_idle = 0;    // last part of the run: no gaps, no stalls
  bit          hold_req = 0;   // ask the receiver for one long hold-off

  imsu_in_if  in_ch ();
  imsu_out_if out_ch ();

  ising_metropolis_spin_update_top u_dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  ising_metropolis_spin_update_checker u_chk (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .in_ch(in_ch), .out_ch(out_ch), .fail_count(fail_count),
    .words_pending(words_pending)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  initial begin
    in_ch.valid = 0;
    in_ch.func = 0;
    in_ch.row = '0;
    in_ch.col = '0;
    in_ch.spin_up_in = 0;
    in_ch.draw = '0;
    out_ch.ready = 0;
  end

  // Hard stop: clearing pass, ~1150 words with their gaps and stalls, and the long hold-off;
  // several times over.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("status: fail");
      $finish;
    end
  end

  // Receiver: random stall bursts, one long hold-off on request.
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ch.ready <= 0;
        repeat (400) @(posedge clk);
        hold_req = 0;
        out_ch.ready <= 1;
      end else if (!no_idle && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 0;
        n = $urandom_range(1, 16);
        repeat (n - 1) @(posedge clk);
      end else begin
        out_ch.ready <= 1;
        n = $urandom_range(1, 20);
        repeat (n - 1) @(posedge clk);
      end
    end
  end

  // Present one word; returns at the edge where it is accepted.
  task automatic send_word(input bit func, input bit [4:0] r, input bit [4:0] c,
                           input bit up, input bit [9:0] draw);
    in_ch.valid <= 1;
    in_ch.func <= func;
    in_ch.row <= r;
    in_ch.col <= c;
    in_ch.spin_up_in <= up;
    in_ch.draw <= draw;
    do @(negedge clk); while (!in_ch.ready);
    @(posedge clk);
  endtask

  // Random sender gap, sometimes.
  task automatic maybe_gap();
    int n;
    if (!no_idle && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 16);
      in_ch.valid <= 0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Drain: wait until every word came back, then let the flip pipeline settle.
  task automatic drain();
    in_ch.valid <= 0;
    do @(negedge clk); while (words_pending != 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [1:0] idx, input logic [15:0] val);
    cfg_we <= 1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic set_cfg(input logic [15:0] j, input logic [15:0] h,
                         input logic [15:0] mu, input logic [15:0] b);
    write_cfg(CFG_COUPLING_J, j);
    write_cfg(CFG_FIELD_H, h);
    write_cfg(CFG_MOMENT_MU, mu);
    write_cfg(CFG_INV_TEMP, b);
  endtask

  // Mostly flips with a fair share of loads; draws mostly in 0..999.
  task automatic random_words(input int count);
    bit [9:0] d;
    for (int i = 0; i < count; i++) begin
      d = ($urandom_range(0, 9) == 0) ? 10'($urandom_range(1000, 1023))
                                      : 10'($urandom_range(0, 999));
      send_word($urandom_range(0, 99) < 65, 5'($urandom), 5'($urandom), 1'($urandom), d);
      maybe_gap();
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1;
    // clearing pass runs with in_ch.ready low
    do @(negedge clk); while (!in_ch.ready);
    @(posedge clk);

    // Directed: lattice corners and wraparound, draw extremes, loads both ways.
    send_word(1, 0, 0, 0, 0);           // all neighbors down, reset couplings
    send_word(1, 0, 0, 0, 999);
    send_word(0, 0, 0, 1, 0);
    send_word(0, 31, 31, 1, 1023);
    send_word(0, 0, 31, 1, 0);
    send_word(0, 31, 0, 0, 0);          // load same value, no sum change
    send_word(1, 31, 0, 0, 1023);       // wrapped neighbors on both axes
    send_word(1, 0, 0, 1, 0);
    send_word(1, 0, 0, 0, 1023);
    send_word(0, 5'h15, 5'h0a, 1, 10'h2aa);
    send_word(1, 5'h0a, 5'h15, 1, 10'h155);
    send_word(0, 0, 0, 0, 0);
    send_word(1, 16, 16, 0, 0);
    drain();

    // Extreme settings, then a few random mixes.
    set_cfg(16'h8000, 16'h7fff, 16'h7fff, 16'hffff);
    send_word(1, 31, 31, 0, 0);
    send_word(1, 1, 1, 0, 999);
    random_words(180);
    drain();

    set_cfg(16'h0000, 16'h8000, 16'h8000, 16'h0000);
    send_word(1, 2, 2, 0, 1023);        // zero beta: dE >= 0 accepted for draws below 1000
    random_words(180);
    drain();

    set_cfg(16'h7fff, 16'h0000, 16'h0000, 16'h0001);
    random_words(150);
    // receiver holds off while words keep coming, filling the block
    hold_req = 1;
    random_words(30);
    drain();

    set_cfg(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom_range(0, 1024)));
    random_words(180);
    // sender pause until every expected result is back
    drain();
    random_words(100);
    drain();

    set_cfg(16'h0100, 16'hff00, 16'h0200, 16'h0400);
    random_words(150);
    drain();

    no_idle = 1;
    set_cfg(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    random_words(150);
    drain();

    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
